@@ rtl/core/ert_pkg.sv @@
// ----------------------------------------------------------------------------
// ert_pkg
// Shared types and codes for the echo reply sequence tracker.
// ----------------------------------------------------------------------------
package ert_pkg;

    localparam int KIND_W   = 2;
    localparam int TIME_W   = 32;
    localparam int LEN_W    = 16;
    localparam int IHL_W    = 4;
    localparam int TYPE_W   = 8;
    localparam int SEQ_W    = 16;
    localparam int STATUS_W = 3;
    localparam int CNT_W    = 11;
    localparam int PREV_W   = 17;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_START = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEND  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REPLY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RSVD  = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TYPE    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

    // accepted ICMP types
    localparam logic [TYPE_W-1:0] ICMP_ECHO_REPLY = 8'd0;
    localparam logic [TYPE_W-1:0] ICMP_TS_REPLY   = 8'd14;

    // minimum ICMP part of a reply, bytes
    localparam logic [LEN_W-1:0] ICMP_MIN_LEN = 16'd8;

    // controller -> datapath
    typedef struct packed {
        logic capture;  // latch the input item
        logic commit;   // apply the update and load the result
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free; // result register can take a new result
    } t_dp_status;

endpackage

@@ rtl/core/ert_ram.sv @@
// ----------------------------------------------------------------------------
// ert_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ert_ram #(
    parameter int WIDTH  = 2,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/ert_ctrl.sv @@
// ----------------------------------------------------------------------------
// ert_ctrl
// Sequencer: capture an item, read its table slot, evaluate and commit.
// ----------------------------------------------------------------------------
module ert_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  ert_pkg::t_dp_status    i_stat,
    output ert_pkg::t_ctrl_cmd     o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                // hold until the result register has room
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

@@ rtl/core/ert_datapath.sv @@
// ----------------------------------------------------------------------------
// ert_datapath
// Item registers, burst counters and flags, probe table, result register.
// ----------------------------------------------------------------------------
module ert_datapath #(
    parameter int PROBE_SLOTS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ert_pkg::t_ctrl_cmd             i_cmd,
    output ert_pkg::t_dp_status            o_stat,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_data,
    input  logic [ert_pkg::KIND_W-1:0]     i_kind,
    input  logic [ert_pkg::TIME_W-1:0]     i_now_us,
    input  logic [ert_pkg::LEN_W-1:0]      i_packet_len,
    input  logic [ert_pkg::IHL_W-1:0]      i_ip_header_words,
    input  logic [ert_pkg::TYPE_W-1:0]     i_reply_type,
    input  logic [ert_pkg::SEQ_W-1:0]      i_reply_seq,
    input  logic [ert_pkg::TIME_W-1:0]     i_sent_stamp,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [ert_pkg::STATUS_W-1:0]   o_status,
    output logic [ert_pkg::SEQ_W-1:0]      o_probe_seq,
    output logic [ert_pkg::TIME_W-1:0]     o_time_value,
    output logic                           o_reply_in_order,
    output logic                           o_first_copy,
    output logic [ert_pkg::CNT_W-1:0]      o_still_outstanding,
    output logic                           o_burst_in_order,
    output logic                           o_burst_duplicate
);

    localparam int SLOT_W = (PROBE_SLOTS > 1) ? $clog2(PROBE_SLOTS) : 1;
    localparam logic [ert_pkg::CNT_W-1:0] SLOTS_CNT = ert_pkg::CNT_W'(PROBE_SLOTS);

    // captured item
    logic [ert_pkg::KIND_W-1:0] r_kind;
    logic [ert_pkg::TIME_W-1:0] r_now;
    logic [ert_pkg::LEN_W-1:0]  r_len;
    logic [ert_pkg::IHL_W-1:0]  r_ihl;
    logic [ert_pkg::TYPE_W-1:0] r_type;
    logic [ert_pkg::SEQ_W-1:0]  r_seq;
    logic [ert_pkg::TIME_W-1:0] r_stamp;

    // burst state
    logic                        r_flag_any_reorder;
    logic [ert_pkg::PREV_W-1:0]  r_prev, n_prev;
    logic [ert_pkg::CNT_W-1:0]   r_sent, n_sent;
    logic [ert_pkg::CNT_W-1:0]   r_pend, n_pend;
    logic                        r_inord, n_inord;
    logic                        r_dup, n_dup;

    logic                        r_out_valid;

    // table: bit 0 seen, bit 1 order
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [1:0]        ram_wdata;
    logic [1:0]        ram_rdata;

    logic [ert_pkg::STATUS_W-1:0] res_status;
    logic [ert_pkg::SEQ_W-1:0]    res_seq;
    logic [ert_pkg::TIME_W-1:0]   res_time;
    logic                         res_ord;
    logic                         res_first;

    logic [ert_pkg::LEN_W-1:0] min_len;
    logic len_ok, type_ok, known, tbl_full, in_seq;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_now   <= i_now_us;
            r_len   <= i_packet_len;
            r_ihl   <= i_ip_header_words;
            r_type  <= i_reply_type;
            r_seq   <= i_reply_seq;
            r_stamp <= i_sent_stamp;
        end
    end

    ert_ram #(
        .WIDTH  (2),
        .DEPTH  (PROBE_SLOTS),
        .ADDR_W (SLOT_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we & i_cmd.commit),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_seq[SLOT_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign min_len  = {{(ert_pkg::LEN_W-ert_pkg::IHL_W-2){1'b0}}, r_ihl, 2'b00}
                      + ert_pkg::ICMP_MIN_LEN;
    assign len_ok   = (r_len >= min_len);
    assign type_ok  = (r_type == ert_pkg::ICMP_ECHO_REPLY) ||
                      (r_type == ert_pkg::ICMP_TS_REPLY);
    assign known    = (r_seq < {{(ert_pkg::SEQ_W-ert_pkg::CNT_W){1'b0}}, r_sent});
    assign tbl_full = (r_sent >= SLOTS_CNT);
    assign in_seq   = ({1'b0, r_seq} == (r_prev + ert_pkg::PREV_W'(1)));

    always_comb begin
        n_prev     = r_prev;
        n_sent     = r_sent;
        n_pend     = r_pend;
        n_inord    = r_inord;
        n_dup      = r_dup;
        res_status = ert_pkg::ST_OK;
        res_seq    = '0;
        res_time   = '0;
        res_ord    = 1'b0;
        res_first  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_sent[SLOT_W-1:0];
        ram_wdata  = 2'b00;
        case (r_kind)
            ert_pkg::KIND_START: begin
                n_prev  = '1;
                n_sent  = '0;
                n_pend  = '0;
                n_inord = 1'b1;
                n_dup   = 1'b0;
            end
            ert_pkg::KIND_SEND: begin
                if (tbl_full) begin
                    res_status = ert_pkg::ST_FULL;
                end else begin
                    res_seq  = {{(ert_pkg::SEQ_W-ert_pkg::CNT_W){1'b0}}, r_sent};
                    res_time = r_now;
                    ram_we   = 1'b1;        // clear seen and order of the new slot
                    n_sent   = r_sent + ert_pkg::CNT_W'(1);
                    n_pend   = r_pend + ert_pkg::CNT_W'(1);
                end
            end
            ert_pkg::KIND_REPLY: begin
                res_seq = r_seq;
                if (!len_ok) begin
                    res_status = ert_pkg::ST_SHORT;
                end else if (!type_ok) begin
                    res_status = ert_pkg::ST_TYPE;
                end else if (!known) begin
                    res_status = ert_pkg::ST_UNKNOWN;
                end else begin
                    res_time = r_now - r_stamp;
                    res_ord  = in_seq;
                    if (!in_seq && r_flag_any_reorder) begin
                        n_inord = 1'b0;
                    end
                    n_prev = {1'b0, r_seq};
                    if (!ram_rdata[0]) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_seq[SLOT_W-1:0];
                        ram_wdata = {in_seq, 1'b1};
                        if (r_pend != '0) begin
                            n_pend = r_pend - ert_pkg::CNT_W'(1);
                        end
                        res_first = 1'b1;
                    end else begin
                        n_dup = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag_any_reorder <= 1'b0;
            r_prev             <= '1;
            r_sent             <= '0;
            r_pend             <= '0;
            r_inord            <= 1'b1;
            r_dup              <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_flag_any_reorder <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                r_prev  <= n_prev;
                r_sent  <= n_sent;
                r_pend  <= n_pend;
                r_inord <= n_inord;
                r_dup   <= n_dup;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit && (r_kind != ert_pkg::KIND_RSVD)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && (r_kind != ert_pkg::KIND_RSVD)) begin
            o_status            <= res_status;
            o_probe_seq         <= res_seq;
            o_time_value        <= res_time;
            o_reply_in_order    <= res_ord;
            o_first_copy        <= res_first;
            o_still_outstanding <= n_pend;
            o_burst_in_order    <= n_inord;
            o_burst_duplicate   <= n_dup;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

endmodule

@@ rtl/core/echo_reply_sequence_tracker.sv @@
// ----------------------------------------------------------------------------
// echo_reply_sequence_tracker
// Sequence, round-trip and duplicate bookkeeping for one burst of echo probes.
// ----------------------------------------------------------------------------
// One item is in flight at a time. A transfer on the input channel is
// followed by a result in the output register once the probe table has
// been read and the item evaluated and committed. Capture, table read and
// evaluation are separate steps; the read of the probe table is registered,
// which is why it has a step of its own. A new input transfer is taken
// while the previous result still waits in the output register; evaluation
// holds only if that register is still occupied when the next result is
// ready. Kind 3 items are taken and produce no result.
// The probe table needs no clearing pass: every slot is cleared when its
// probe is sent, and only the contents of sent slots are ever used.
// ----------------------------------------------------------------------------
module echo_reply_sequence_tracker #(
    parameter int PROBE_SLOTS = 16      // 1 .. 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration: flag_any_reorder
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_data,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [ert_pkg::KIND_W-1:0]     i_kind,
    input  logic [ert_pkg::TIME_W-1:0]     i_now_us,
    input  logic [ert_pkg::LEN_W-1:0]      i_packet_len,
    input  logic [ert_pkg::IHL_W-1:0]      i_ip_header_words,
    input  logic [ert_pkg::TYPE_W-1:0]     i_reply_type,
    input  logic [ert_pkg::SEQ_W-1:0]      i_reply_seq,
    input  logic [ert_pkg::TIME_W-1:0]     i_sent_stamp,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [ert_pkg::STATUS_W-1:0]   o_status,
    output logic [ert_pkg::SEQ_W-1:0]      o_probe_seq,
    output logic [ert_pkg::TIME_W-1:0]     o_time_value,
    output logic                           o_reply_in_order,
    output logic                           o_first_copy,
    output logic [ert_pkg::CNT_W-1:0]      o_still_outstanding,
    output logic                           o_burst_in_order,
    output logic                           o_burst_duplicate
);

    ert_pkg::t_ctrl_cmd  cmd;
    ert_pkg::t_dp_status stat;

    // sequencer: idle -> read -> evaluate
    ert_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // counters, flags, probe table and result register
    ert_datapath #(
        .PROBE_SLOTS (PROBE_SLOTS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_data          (i_cfg_data),
        .i_kind              (i_kind),
        .i_now_us            (i_now_us),
        .i_packet_len        (i_packet_len),
        .i_ip_header_words   (i_ip_header_words),
        .i_reply_type        (i_reply_type),
        .i_reply_seq         (i_reply_seq),
        .i_sent_stamp        (i_sent_stamp),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_status            (o_status),
        .o_probe_seq         (o_probe_seq),
        .o_time_value        (o_time_value),
        .o_reply_in_order    (o_reply_in_order),
        .o_first_copy        (o_first_copy),
        .o_still_outstanding (o_still_outstanding),
        .o_burst_in_order    (o_burst_in_order),
        .o_burst_duplicate   (o_burst_duplicate)
    );

`ifndef SYNTHESIS
    // a new result only appears right after a commit
    a_result_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cmd.commit))
        else $error("result appeared without a commit");

    // a captured item keeps the input side stalled while it is worked on
    a_busy_after_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture |=> o_in_stall)
        else $error("input not stalled after capture");

    // outstanding count never exceeds the table size
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_still_outstanding <= ert_pkg::CNT_W'(PROBE_SLOTS)))
        else $error("outstanding count beyond table size");

    // a first copy is only reported on an accepted reply
    a_first_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_first_copy) |-> (o_status == ert_pkg::ST_OK))
        else $error("first copy with a drop status");
`endif

endmodule
